FILE: design/dbeg_pkg.sv
// ----------------------------------------------------------------------------
// dbeg_pkg
// Shared types and constants of the beep tone generator: register map,
// configuration record and the tone stage record.
// ----------------------------------------------------------------------------
package dbeg_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int PHASE_W    = 32;
	localparam int AMP_W      = 20;
	localparam int TICK_W     = 16;
	localparam int STEP_W     = 16;
	localparam int DAC_W      = 16;
	localparam int ROM_W      = 27;

	localparam logic [DAC_W-1:0] DAC_CTRL = 16'b1011000000000000;
	localparam logic [DAC_W-1:0] MID_CODE = 16'd2048;

	localparam logic [PHASE_W-1:0] RST_PHASE_INC    = 32'd42949672;
	localparam logic [STEP_W-1:0]  RST_ATTACK_STEP  = 16'd163;
	localparam logic [STEP_W-1:0]  RST_DECAY_STEP   = 16'd163;
	localparam logic [TICK_W-1:0]  RST_ATTACK_TICKS = 16'd200;
	localparam logic [TICK_W-1:0]  RST_DECAY_TICKS  = 16'd200;
	localparam logic [TICK_W-1:0]  RST_BEEP_TICKS   = 16'd10400;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PHASE_INC    = 3'd0,
		REG_ATTACK_STEP  = 3'd1,
		REG_DECAY_STEP   = 3'd2,
		REG_ATTACK_TICKS = 3'd3,
		REG_DECAY_TICKS  = 3'd4,
		REG_BEEP_TICKS   = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase_inc;
		logic [STEP_W-1:0]  attack_step;
		logic [STEP_W-1:0]  decay_step;
		logic [TICK_W-1:0]  attack_ticks;
		logic [TICK_W-1:0]  decay_ticks;
		logic [TICK_W-1:0]  beep_ticks;
	} cfg_t;

	// one tone tick on its way to the sine lookup
	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [AMP_W-1:0]   amp;
	} tone_t;

endpackage

FILE: design/dbeg_if.sv
// ----------------------------------------------------------------------------
// dbeg_if
// Channel interfaces: sample tick input, dac word output, register writes.
// ----------------------------------------------------------------------------
interface dbeg_tick_if;
	logic valid;
	logic ready;
	logic start_beep;

	modport source (output valid, output start_beep, input ready);
	modport sink (input valid, input start_beep, output ready);
endinterface

interface dbeg_dac_if;
	logic                        valid;
	logic                        ready;
	logic [dbeg_pkg::DAC_W-1:0]  dac_word;

	modport source (output valid, output dac_word, input ready);
	modport sink (input valid, input dac_word, output ready);
endinterface

interface dbeg_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [dbeg_pkg::CFG_IDX_W-1:0]   index;
	logic [dbeg_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/dbeg_cfg.sv
// ----------------------------------------------------------------------------
// dbeg_cfg
// Configuration register file, written through the register write channel.
// ----------------------------------------------------------------------------
module dbeg_cfg (
	input  logic               clk,
	input  logic               arst_n,
	dbeg_cfg_if.sink           cfg,
	output dbeg_pkg::cfg_t     regs
);

	dbeg_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.phase_inc    <= dbeg_pkg::RST_PHASE_INC;
			regs_q.attack_step  <= dbeg_pkg::RST_ATTACK_STEP;
			regs_q.decay_step   <= dbeg_pkg::RST_DECAY_STEP;
			regs_q.attack_ticks <= dbeg_pkg::RST_ATTACK_TICKS;
			regs_q.decay_ticks  <= dbeg_pkg::RST_DECAY_TICKS;
			regs_q.beep_ticks   <= dbeg_pkg::RST_BEEP_TICKS;
		end else if (cfg.valid && cfg.ready) begin
			case (dbeg_pkg::reg_idx_t'(cfg.index))
				dbeg_pkg::REG_PHASE_INC: begin
					regs_q.phase_inc <= cfg.data[dbeg_pkg::PHASE_W-1:0];
				end
				dbeg_pkg::REG_ATTACK_STEP: begin
					regs_q.attack_step <= cfg.data[dbeg_pkg::STEP_W-1:0];
				end
				dbeg_pkg::REG_DECAY_STEP: begin
					regs_q.decay_step <= cfg.data[dbeg_pkg::STEP_W-1:0];
				end
				dbeg_pkg::REG_ATTACK_TICKS: begin
					regs_q.attack_ticks <= cfg.data[dbeg_pkg::TICK_W-1:0];
				end
				dbeg_pkg::REG_DECAY_TICKS: begin
					regs_q.decay_ticks <= cfg.data[dbeg_pkg::TICK_W-1:0];
				end
				dbeg_pkg::REG_BEEP_TICKS: begin
					regs_q.beep_ticks <= cfg.data[dbeg_pkg::TICK_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: design/dbeg_env.sv
// ----------------------------------------------------------------------------
// dbeg_env
// Beep sequencing and envelope: pending flag, tick count, phase accumulator
// and amplitude ramp. A tone tick leaves through the first stage register.
// ----------------------------------------------------------------------------
module dbeg_env (
	input  logic                clk,
	input  logic                arst_n,
	dbeg_tick_if.sink           tick,
	input  dbeg_pkg::cfg_t      regs,
	input  logic                adv_s1,
	output dbeg_pkg::tone_t     data_s1,
	output logic                valid_s1
);

	logic                          pending_q;
	logic                          done_q;
	logic [dbeg_pkg::TICK_W-1:0]   count_q;
	logic [dbeg_pkg::PHASE_W-1:0]  phase_q;
	logic [dbeg_pkg::AMP_W-1:0]    amp_q;

	logic                          take;
	logic                          pending;
	logic                          tone;
	logic [dbeg_pkg::PHASE_W-1:0]  phase_next;
	logic [dbeg_pkg::AMP_W-1:0]    amp_next;
	logic [dbeg_pkg::TICK_W-1:0]   count_inc;
	logic [dbeg_pkg::TICK_W:0]     decay_sum;
	logic                          in_attack;
	logic                          in_decay;

	assign tick.ready = !valid_s1 || adv_s1;
	assign take       = tick.valid && tick.ready;
	assign pending    = pending_q || tick.start_beep;
	assign tone       = pending && !done_q;

	assign phase_next = phase_q + regs.phase_inc;
	assign count_inc  = count_q + 1'b1;
	assign decay_sum  = {1'b0, count_q} + {1'b0, regs.decay_ticks};
	assign in_attack  = count_q < regs.attack_ticks;
	assign in_decay   = decay_sum > {1'b0, regs.beep_ticks};

	always_comb begin
		amp_next = amp_q;
		if (in_attack) begin
			amp_next = amp_q + dbeg_pkg::AMP_W'(regs.attack_step);
		end else if (in_decay) begin
			amp_next = amp_q - dbeg_pkg::AMP_W'(regs.decay_step);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			done_q    <= 1'b0;
			count_q   <= '0;
			phase_q   <= '0;
			amp_q     <= '0;
			valid_s1  <= 1'b0;
		end else begin
			if (tick.ready) begin
				valid_s1 <= take && tone;
			end
			if (take && pending) begin
				if (done_q) begin
					// idle tick after the tone: clear and emit nothing
					pending_q <= 1'b0;
					done_q    <= 1'b0;
					count_q   <= '0;
					amp_q     <= '0;
				end else begin
					pending_q <= 1'b1;
					phase_q   <= phase_next;
					amp_q     <= amp_next;
					if (count_inc == regs.beep_ticks) begin
						done_q  <= 1'b1;
						count_q <= '0;
					end else begin
						count_q <= count_inc;
					end
				end
			end
		end
	end

	// sample uses the amplitude from before this tick's ramp step
	always_ff @(posedge clk) begin
		if (take && tone) begin
			data_s1.phase <= phase_next;
			data_s1.amp   <= amp_q;
		end
	end

endmodule

FILE: design/dbeg_rom.sv
// ----------------------------------------------------------------------------
// dbeg_rom
// Scaled sine table with registered read. Contents are built at elaboration
// from a fixed-point Taylor series, entry i = 2047*32768*sin(6.283*i/depth).
// ----------------------------------------------------------------------------
module dbeg_rom #(
	parameter int SINE_DEPTH = 256
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic [$clog2(SINE_DEPTH)-1:0]        idx,
	output logic signed [dbeg_pkg::ROM_W-1:0]    data
);

	localparam logic [63:0] PI_Q60    = 64'h3243F6A8885A308D;
	localparam logic [63:0] ROM_SCALE = 64'd67076096;

	typedef logic signed [dbeg_pkg::ROM_W-1:0] rom_arr_t [SINE_DEPTH];

	// shift-subtract quotient, elaboration only
	function automatic logic [127:0] udiv(input logic [127:0] n, input logic [127:0] d);
		logic [127:0] q;
		logic [127:0] r;
		q = '0;
		r = '0;
		for (int b = 127; b >= 0; b--) begin
			r = {r[126:0], n[b]};
			if (r >= d) begin
				r    = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'b0, a} * {64'b0, b};
		return p[123:60];
	endfunction

	function automatic logic [dbeg_pkg::ROM_W-1:0] rom_entry(input int i);
		logic [127:0] num;
		logic [127:0] den;
		logic [63:0]  theta;
		logic [63:0]  t2;
		logic [63:0]  term;
		logic [63:0]  sum;
		logic [63:0]  v;
		logic [31:0]  w;
		logic         neg;
		num   = 128'(6283) * 128'(i);
		den   = 128'(1000) * 128'(SINE_DEPTH);
		theta = 64'(udiv(num << 60, den));
		neg   = 1'b0;
		if (theta >= PI_Q60) begin
			theta = theta - PI_Q60;
			neg   = 1'b1;
		end
		if (theta > (PI_Q60 >> 1)) begin
			theta = PI_Q60 - theta;
		end
		t2   = mul_q60(theta, theta);
		term = theta;
		sum  = theta;
		for (int k = 1; k <= 12; k++) begin
			term = 64'(udiv({64'b0, mul_q60(term, t2)}, 128'((2 * k) * (2 * k + 1))));
			if ((k & 1) != 0) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		v = mul_q60(sum, ROM_SCALE);
		w = v[31:0];
		if (neg) begin
			w = -w;
		end
		return w[dbeg_pkg::ROM_W-1:0];
	endfunction

	function automatic rom_arr_t build_rom();
		rom_arr_t t;
		for (int i = 0; i < SINE_DEPTH; i++) begin
			t[i] = rom_entry(i);
		end
		return t;
	endfunction

	localparam rom_arr_t SINE = build_rom();

	always_ff @(posedge clk) begin
		if (en) begin
			data <= SINE[idx];
		end
	end

endmodule

FILE: design/dbeg_pipe.sv
// ----------------------------------------------------------------------------
// dbeg_pipe
// Sample path: phase to table index, sine lookup, amplitude multiply and
// dac word formatting, with per-stage valid so bubbles collapse on a stall.
// ----------------------------------------------------------------------------
module dbeg_pipe #(
	parameter int SINE_DEPTH = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dbeg_pkg::tone_t     data_s1,
	input  logic                valid_s1,
	output logic                adv_s1,
	dbeg_dac_if.source          dac
);

	localparam int IDX_W  = $clog2(SINE_DEPTH);
	localparam int PROD_W = dbeg_pkg::PHASE_W + IDX_W;

	logic [IDX_W-1:0]                   idx_s2;
	logic [dbeg_pkg::AMP_W-1:0]         amp_s2;
	logic                               valid_s2;
	logic [dbeg_pkg::AMP_W-1:0]         amp_s3;
	logic signed [dbeg_pkg::ROM_W-1:0]  rom_s3;
	logic                               valid_s3;
	logic [dbeg_pkg::DAC_W-1:0]         dac_q;
	logic                               valid_q;

	logic                               adv_s2;
	logic                               adv_s3;
	logic                               adv_out;
	logic [PROD_W-1:0]                  idx_prod;
	logic signed [dbeg_pkg::AMP_W+dbeg_pkg::ROM_W-1:0] sample_prod;
	logic [dbeg_pkg::DAC_W-1:0]         sample;

	assign adv_out = !valid_q || dac.ready;
	assign adv_s3  = !valid_s3 || adv_out;
	assign adv_s2  = !valid_s2 || adv_s3;
	assign adv_s1  = adv_s2;

	// index = (phase * depth) >> 32
	assign idx_prod = PROD_W'(data_s1.phase) * PROD_W'(SINE_DEPTH);

	// floor shift by 30, low 16 bits, plus mid code
	assign sample_prod = $signed(amp_s3) * rom_s3;
	assign sample = sample_prod[30 +: dbeg_pkg::DAC_W] + dbeg_pkg::MID_CODE;

	dbeg_rom #(
		.SINE_DEPTH(SINE_DEPTH)
	) u_rom (
		.clk (clk),
		.en  (adv_s3),
		.idx (idx_s2),
		.data(rom_s3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s3) begin
				valid_s3 <= valid_s2;
			end
			if (adv_out) begin
				valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			idx_s2 <= idx_prod[dbeg_pkg::PHASE_W +: IDX_W];
			amp_s2 <= data_s1.amp;
		end
		if (adv_s3) begin
			amp_s3 <= amp_s2;
		end
		if (adv_out) begin
			dac_q <= dbeg_pkg::DAC_CTRL | sample;
		end
	end

	assign dac.valid    = valid_q;
	assign dac.dac_word = dac_q;

endmodule

FILE: design/dds_beep_envelope_generator.sv
// ----------------------------------------------------------------------------
// dds_beep_envelope_generator
// Beep tone source: phase accumulator, sine table and attack/decay envelope.
// ----------------------------------------------------------------------------
// path: a dac word passes stage registers s1, s2 and s3 and the output register after its tick transfer
// throughput: one tick per cycle while dac.ready lets the stage chain advance; the chain stalls only on dac.ready
// ticks that produce no word are taken and leave no bubble
// reset: clears beep state, phase, amplitude and stage valids, loads the
// register defaults; the sine table is constant and needs no clearing
module dds_beep_envelope_generator #(
	parameter int SINE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	dbeg_tick_if.sink   tick,
	dbeg_dac_if.source  dac,
	dbeg_cfg_if.sink    cfg
);

	dbeg_pkg::cfg_t   regs;
	dbeg_pkg::tone_t  data_s1;
	logic             valid_s1;
	logic             adv_s1;

	dbeg_cfg u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.regs  (regs)
	);

	dbeg_env u_env (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick),
		.regs    (regs),
		.adv_s1  (adv_s1),
		.data_s1 (data_s1),
		.valid_s1(valid_s1)
	);

	dbeg_pipe #(
		.SINE_DEPTH(SINE_DEPTH)
	) u_pipe (
		.clk     (clk),
		.arst_n  (arst_n),
		.data_s1 (data_s1),
		.valid_s1(valid_s1),
		.adv_s1  (adv_s1),
		.dac     (dac)
	);

endmodule

FILE: verif/tb_dds_beep_envelope_generator.sv
// ----------------------------------------------------------------------------
// tb_dds_beep_envelope_generator
// Drives sample ticks with beep requests and register writes into the beep
// tone generator and checks every dac word against a cycle-free model of the
// phase accumulator, sine table and attack/decay envelope. Runs directed
// corner cases, randomized register settings with random idling on both
// channels, a long output stall, a drain pause, a longer beep and a beep
// with a zero length setting that runs on past a short count.
// ----------------------------------------------------------------------------
module tb_dds_beep_envelope_generator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned PI_Q60    = 64'h3243F6A8885A308D;
	localparam longint unsigned SINE_GAIN = 64'd67076096;
	localparam int              CYCLE_LIMIT = 400000;
	localparam int              SETTLE_CYCLES = 8;

	class tone_checker;
		logic [dbeg_pkg::PHASE_W-1:0] phase_inc;
		logic [dbeg_pkg::STEP_W-1:0]  attack_step;
		logic [dbeg_pkg::STEP_W-1:0]  decay_step;
		logic [dbeg_pkg::TICK_W-1:0]  attack_ticks;
		logic [dbeg_pkg::TICK_W-1:0]  decay_ticks;
		logic [dbeg_pkg::TICK_W-1:0]  beep_ticks;

		bit                           pending;
		bit                           done;
		logic [dbeg_pkg::TICK_W-1:0]  tick_count;
		logic [dbeg_pkg::PHASE_W-1:0] phase_acc;
		logic [dbeg_pkg::AMP_W-1:0]   amp;

		int                           sine_tab[256];
		logic [dbeg_pkg::DAC_W-1:0]   expected_words[$];
		int                           errors;

		function new();
			for (int i = 0; i < 256; i++) begin
				sine_tab[i] = sine_entry(i);
			end
			phase_inc    = dbeg_pkg::RST_PHASE_INC;
			attack_step  = dbeg_pkg::RST_ATTACK_STEP;
			decay_step   = dbeg_pkg::RST_DECAY_STEP;
			attack_ticks = dbeg_pkg::RST_ATTACK_TICKS;
			decay_ticks  = dbeg_pkg::RST_DECAY_TICKS;
			beep_ticks   = dbeg_pkg::RST_BEEP_TICKS;
			pending      = 0;
			done         = 0;
			tick_count   = '0;
			phase_acc    = '0;
			amp          = '0;
			errors       = 0;
		endfunction

		// (a * b) >> 60 kept to 64 bits
		function longint unsigned mul_q60(longint unsigned a, longint unsigned b);
			bit [127:0] prod;
			prod = {64'd0, a} * {64'd0, b};
			return prod[123:60];
		endfunction

		// sin(6.283 * i / 256) by Taylor series in Q60, scaled by 2047 * 32768
		function int sine_entry(int i);
			longint unsigned num, den, theta, r, t2, term, sum, v;
			bit              neg;
			num   = 64'd6283 * longint'(i);
			den   = 64'd256000;
			theta = (num / den) << 60;
			r     = num % den;
			neg   = 0;
			for (int b = 59; b >= 0; b--) begin
				r = r << 1;
				if (r >= den) begin
					r     = r - den;
					theta = theta | (64'd1 << b);
				end
			end
			if (theta >= PI_Q60) begin
				theta = theta - PI_Q60;
				neg   = 1;
			end
			if (theta > (PI_Q60 >> 1))
				theta = PI_Q60 - theta;
			t2   = mul_q60(theta, theta);
			term = theta;
			sum  = theta;
			for (int k = 1; k <= 12; k++) begin
				term = mul_q60(term, t2) / longint'((2 * k) * (2 * k + 1));
				if (k % 2 == 1)
					sum = sum - term;
				else
					sum = sum + term;
			end
			v = mul_q60(sum, SINE_GAIN);
			return neg ? -int'(v) : int'(v);
		endfunction

		function void set_reg(dbeg_pkg::reg_idx_t idx, logic [dbeg_pkg::CFG_DATA_W-1:0] d);
			case (idx)
				dbeg_pkg::REG_PHASE_INC:    phase_inc    = d;
				dbeg_pkg::REG_ATTACK_STEP:  attack_step  = d[dbeg_pkg::STEP_W-1:0];
				dbeg_pkg::REG_DECAY_STEP:   decay_step   = d[dbeg_pkg::STEP_W-1:0];
				dbeg_pkg::REG_ATTACK_TICKS: attack_ticks = d[dbeg_pkg::TICK_W-1:0];
				dbeg_pkg::REG_DECAY_TICKS:  decay_ticks  = d[dbeg_pkg::TICK_W-1:0];
				dbeg_pkg::REG_BEEP_TICKS:   beep_ticks   = d[dbeg_pkg::TICK_W-1:0];
				default: ;
			endcase
		endfunction

		// one accepted tick; returns 1 when the tick moved the beep state
		function bit note_tick(bit start);
			longint    a64, p, q, s;
			logic [7:0] idx;
			if (start)
				pending = 1;
			if (!pending)
				return 0;
			if (done) begin
				// idle tick after the tone clears everything, no word
				amp        = '0;
				done       = 0;
				tick_count = '0;
				pending    = 0;
				return 1;
			end
			phase_acc = phase_acc + phase_inc;
			idx       = phase_acc[31:24];
			a64       = {{44{amp[dbeg_pkg::AMP_W-1]}}, amp};
			p         = a64 * longint'(sine_tab[idx]);
			q         = p >>> 30;
			if (tick_count < attack_ticks)
				amp = amp + dbeg_pkg::AMP_W'(attack_step);
			else if ({1'b0, tick_count} + {1'b0, decay_ticks} > {1'b0, beep_ticks})
				amp = amp - dbeg_pkg::AMP_W'(decay_step);
			s = q + 64'sd2048;
			expected_words.push_back(dbeg_pkg::DAC_CTRL | s[15:0]);
			tick_count = tick_count + 1'b1;
			if (tick_count == beep_ticks) begin
				done       = 1;
				tick_count = '0;
			end
			return 1;
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_word(logic [dbeg_pkg::DAC_W-1:0] w);
			logic [dbeg_pkg::DAC_W-1:0] exp_w;
			if (expected_words.size() == 0) begin
				report($sformatf("dac word %h with nothing expected", w));
			end else begin
				exp_w = expected_words.pop_front();
				if (w !== exp_w)
					report($sformatf("dac_word %h, expected %h", w, exp_w));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	dbeg_tick_if tick_ch ();
	dbeg_dac_if  dac_ch ();
	dbeg_cfg_if  cfg_ch ();

	dds_beep_envelope_generator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.dac    (dac_ch),
		.cfg    (cfg_ch)
	);

	tone_checker sb;
	int          src_max = 17;
	int          snk_max = 17;
	int          hold_cycles = 0;
	int          cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_dds_beep_envelope_generator: FAIL");
			$finish;
		end
	end

	// dac side: random ready gaps, plus one long hold when asked
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_cycles > 0) begin
				dac_ch.ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			gap = (snk_max > 0) ? $urandom_range(0, snk_max) : 0;
			if (gap > 0) begin
				dac_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			dac_ch.ready <= 1'b1;
			@(posedge clk);
			while (!dac_ch.valid) @(posedge clk);
			sb.check_word(dac_ch.dac_word);
		end
	end

	task send_tick(input bit start, output bit active);
		int gap;
		gap = (src_max > 0) ? $urandom_range(0, src_max) : 0;
		if (gap > 0) begin
			tick_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_ch.valid      <= 1'b1;
		tick_ch.start_beep <= start;
		@(posedge clk);
		while (!tick_ch.ready) @(posedge clk);
		active = sb.note_tick(start);
	endtask

	task tick_stop();
		tick_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task wait_drained();
		while (sb.expected_words.size() != 0) @(posedge clk);
		// clearing ticks leave no word behind, give them time to pass
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task finish_beep();
		bit act;
		while (sb.pending) send_tick(1'b0, act);
	endtask

	task write_reg(dbeg_pkg::reg_idx_t idx, logic [dbeg_pkg::CFG_DATA_W-1:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= d;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		sb.set_reg(idx, d);
	endtask

	task apply_setting(logic [31:0] inc, logic [15:0] ast, logic [15:0] dst,
			logic [15:0] at, logic [15:0] dt, logic [15:0] bt, bit drain);
		if (drain)
			finish_beep();
		tick_stop();
		wait_drained();
		write_reg(dbeg_pkg::REG_PHASE_INC, inc);
		write_reg(dbeg_pkg::REG_ATTACK_STEP, {16'd0, ast});
		write_reg(dbeg_pkg::REG_DECAY_STEP, {16'd0, dst});
		write_reg(dbeg_pkg::REG_ATTACK_TICKS, {16'd0, at});
		write_reg(dbeg_pkg::REG_DECAY_TICKS, {16'd0, dt});
		write_reg(dbeg_pkg::REG_BEEP_TICKS, {16'd0, bt});
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	function logic [15:0] pick_step();
		case ($urandom_range(0, 3))
			0: return 16'd0;
			1: return 16'd32768;
			default: return 16'($urandom_range(0, 32768));
		endcase
	endfunction

	function logic [15:0] pick_ramp(int bt);
		case ($urandom_range(0, 3))
			0: return 16'd0;
			1: return 16'hffff;
			default: return 16'($urandom_range(0, bt + 4));
		endcase
	endfunction

	initial begin
		bit          act;
		bit          paused;
		int          count;
		logic [31:0] r_inc;
		logic [15:0] r_bt;

		sb = new();
		arst_n             <= 1'b0;
		tick_ch.valid      <= 1'b0;
		tick_ch.start_beep <= 1'b0;
		dac_ch.ready       <= 1'b0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.index       <= dbeg_pkg::REG_PHASE_INC;
		cfg_ch.data        <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults: a tick with nothing pending, then a beep start
		send_tick(1'b0, act);
		send_tick(1'b1, act);
		repeat (3) send_tick(1'b0, act);

		// full-scale steps mid-beep, decay window wider than the beep
		apply_setting(32'hffffffff, 16'd32768, 16'd32768, 16'd3, 16'd20, 16'd10, 1'b0);
		repeat (6) send_tick(1'b0, act);
		send_tick(1'b1, act);   // request lands on the clearing tick
		send_tick(1'b0, act);
		send_tick(1'b1, act);
		repeat (4) send_tick(1'b0, act);

		// all-zero setting with one-tick beeps
		apply_setting(32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 1'b1);
		repeat (4) send_tick(1'b1, act);

		for (int ph = 0; ph < 10; ph++) begin
			if (ph == 0) begin
				// amplitude overflows through 20 bits
				apply_setting(32'hffffffff, 16'd32768, 16'd32768, 16'hffff, 16'hffff,
					16'd48, 1'b1);
			end else if (ph == 1) begin
				apply_setting(32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 1'b1);
			end else begin
				case ($urandom_range(0, 3))
					0: r_inc = 32'd0;
					1: r_inc = 32'hffffffff;
					default: r_inc = $urandom;
				endcase
				r_bt = 16'($urandom_range(1, 48));
				apply_setting(r_inc, pick_step(), pick_step(), pick_ramp(r_bt),
					pick_ramp(r_bt), r_bt, 1'b1);
			end
			src_max = (ph % 3 == 1) ? 0 : 17;
			snk_max = (ph % 4 == 2) ? 0 : 17;
			if (ph == 3)
				hold_cycles = 300;
			count  = 0;
			paused = 0;
			while (count < 40) begin
				if (ph == 5 && count >= 20 && !paused) begin
					tick_stop();
					while (sb.expected_words.size() != 0) @(posedge clk);
					paused = 1;
				end
				send_tick($urandom_range(0, 9) == 0, act);
				count += act;
			end
		end

		// a longer beep, then a zero length that keeps counting past a short beep
		src_max = 0;
		snk_max = 0;
		r_inc   = $urandom;
		apply_setting(r_inc, 16'd16, 16'd16, 16'd20, 16'd80, 16'd64, 1'b1);
		send_tick(1'b1, act);
		apply_setting(r_inc, 16'd7, 16'd5, 16'd40, 16'hffff, 16'd0, 1'b1);
		send_tick(1'b1, act);
		repeat (79) send_tick(1'b0, act);
		apply_setting(r_inc, 16'd7, 16'd5, 16'd40, 16'hffff, 16'd100, 1'b0);
		finish_beep();

		tick_stop();
		wait_drained();
		if (sb.errors == 0)
			$display("tb_dds_beep_envelope_generator: PASS");
		else
			$display("tb_dds_beep_envelope_generator: FAIL");
		$finish;
	end

endmodule
